/* rtl/core/bsn_pkg.sv */
// Shared types, constants and helpers for the BGR scaler to NV12 unit.
// No dependencies; every other file of the block but bsn_div imports this package.
package bsn_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned REG_W     = 13;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // Default largest frame dimension.
  localparam int unsigned MAX_DIM_DEF = 4096;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_TILE_WIDTH = 2'd2,
    CFG_TILE_HEIGHT = 2'd3
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [REG_W-1:0] SRC_WIDTH_RST   = REG_W'(640);
  localparam logic [REG_W-1:0] SRC_HEIGHT_RST  = REG_W'(480);
  localparam logic [REG_W-1:0] TILE_WIDTH_RST  = REG_W'(320);
  localparam logic [REG_W-1:0] TILE_HEIGHT_RST = REG_W'(240);

  // Color conversion accumulators: 16-bit fractions of BT.601 full range.
  localparam int unsigned ACC_W  = 26;
  localparam int unsigned FRAC_W = 16;
  localparam logic signed [ACC_W-1:0] Y_R        = ACC_W'(19595);
  localparam logic signed [ACC_W-1:0] Y_G        = ACC_W'(38470);
  localparam logic signed [ACC_W-1:0] Y_B        = ACC_W'(7471);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] CB_R       = ACC_W'(11058);
  localparam logic signed [ACC_W-1:0] CB_G       = ACC_W'(21710);
  localparam logic signed [ACC_W-1:0] CB_B       = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] CR_R       = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] CR_G       = ACC_W'(27439);
  localparam logic signed [ACC_W-1:0] CR_B       = ACC_W'(5329);
  // 128 in the integer part plus the rounding half.
  localparam logic signed [ACC_W-1:0] CHROMA_OFS = ACC_W'(8421376);
  localparam logic signed [ACC_W-1:0] PIX_MAX    = ACC_W'(255);

  // Chroma value sent when the sample carries no chroma.
  localparam logic [PIX_W-1:0] CHROMA_MID = PIX_W'(128);

  // Status of the setup sequencer as seen by the datapath.
  typedef struct packed {
    logic busy;      // Scale factors are being recomputed.
    logic fix_load;  // First-step correction values are now valid.
  } seq_status_t;

  // Drop the fraction and clamp an accumulator to the pixel range.
  function automatic logic [PIX_W-1:0] clamp8(logic signed [ACC_W-1:0] t);
    logic signed [ACC_W-1:0] v;
    v = t >>> FRAC_W;
    if (t < 0) begin
      return '0;
    end else if (v > PIX_MAX) begin
      return PIX_W'(255);
    end
    return v[PIX_W-1:0];
  endfunction

endpackage

/* rtl/core/bgr_scale_to_nv12_unit.sv */
// Top level of the BGR scaler to NV12 unit: setup sequencer and datapath.
// Depends on bsn_pkg, bsn_setup and bsn_core.
//
// The unit takes one BGR pixel per clock in raster order while in_stall_o is
// low and emits at most one NV12 sample per pixel: the input register takes
// the pixel and the result register takes its sample; while a result stalls,
// an empty input register can still take the next pixel. After reset and
// after every configuration write the unit holds in_stall_o high while its
// serial divider derives the column and row step sizes: a load state, then
// four divisions (column base, column correction, row base, row correction)
// of DIM + 1 quotient bits each, where DIM = 13 bits for the default MAX_DIM
// of 4096.
// Write all size registers first and then start the pixel stream.
module bgr_scale_to_nv12_unit #(
  parameter int unsigned MAX_DIM = bsn_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsn_pkg::REG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsn_pkg::PIX_W-1:0]     blue_i,
  input  logic [bsn_pkg::PIX_W-1:0]     green_i,
  input  logic [bsn_pkg::PIX_W-1:0]     red_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsn_pkg::PIX_W-1:0]     luma_o,
  output logic [bsn_pkg::PIX_W-1:0]     chroma_blue_o,
  output logic [bsn_pkg::PIX_W-1:0]     chroma_red_o,
  output logic                          chroma_valid_o,
  output logic [bsn_pkg::POS_W-1:0]     tile_col_o,
  output logic [bsn_pkg::POS_W-1:0]     tile_row_o,
  output logic                          tile_last_o
);

  import bsn_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned DIV_W = DIM_W + 1;

  logic [DIM_W-1:0] sw, sh, tw, th;
  logic [DIV_W-1:0] col_bq, col_fq, row_bq, row_fq;
  logic [DIM_W-1:0] col_br, col_fr, row_br, row_fr;
  logic [DIM_W-1:0] col_rem, row_rem;
  seq_status_t      status;

  // Configuration and step-size derivation.
  bsn_setup #(
    .MAX_DIM(MAX_DIM)
  ) u_setup (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .col_rem_i   (col_rem),
    .row_rem_i   (row_rem),
    .sw_o        (sw),
    .sh_o        (sh),
    .tw_o        (tw),
    .th_o        (th),
    .col_base_q_o(col_bq),
    .col_base_r_o(col_br),
    .col_fix_q_o (col_fq),
    .col_fix_r_o (col_fr),
    .row_base_q_o(row_bq),
    .row_base_r_o(row_br),
    .row_fix_q_o (row_fq),
    .row_fix_r_o (row_fr),
    .status_o    (status)
  );

  // Pixel datapath.
  bsn_core #(
    .MAX_DIM(MAX_DIM)
  ) u_core (
    .clk_i,
    .rst_ni,
    .sw_i          (sw),
    .sh_i          (sh),
    .tw_i          (tw),
    .th_i          (th),
    .col_base_q_i  (col_bq),
    .col_base_r_i  (col_br),
    .col_fix_q_i   (col_fq),
    .col_fix_r_i   (col_fr),
    .row_base_q_i  (row_bq),
    .row_base_r_i  (row_br),
    .row_fix_q_i   (row_fq),
    .row_fix_r_i   (row_fr),
    .status_i      (status),
    .col_rem_o     (col_rem),
    .row_rem_o     (row_rem),
    .in_valid_i,
    .in_stall_o,
    .blue_i,
    .green_i,
    .red_i,
    .frame_start_i,
    .out_valid_o,
    .out_stall_i,
    .luma_o,
    .chroma_blue_o,
    .chroma_red_o,
    .chroma_valid_o,
    .tile_col_o,
    .tile_row_o,
    .tile_last_o
  );

endmodule

/* rtl/core/bsn_div.sv */
// Restoring divider, one quotient bit per cycle, used by the setup sequencer.
// Depends on nothing but its parameters.
module bsn_div #(
  parameter int unsigned DEND_W = 14,
  parameter int unsigned DSOR_W = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DEND_W-1:0] dividend_i,
  input  logic [DSOR_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DEND_W-1:0] quo_o,
  output logic [DSOR_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DEND_W + 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DEND_W-1:0] quo_q, quo_d;
  logic [DSOR_W-1:0] rem_q, rem_d;
  logic [DSOR_W-1:0] dsor_q, dsor_d;
  logic [DSOR_W:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try to subtract.
  assign trial = {rem_q, quo_q[DEND_W-1]};
  assign fits  = trial >= {1'b0, dsor_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsor_d = dsor_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CNT_W'(DEND_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsor_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[DEND_W-2:0], fits};
      rem_d = fits ? DSOR_W'(trial - {1'b0, dsor_q}) : DSOR_W'(trial);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dsor_q <= dsor_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/bsn_setup.sv */
// Configuration registers, effective frame and tile sizes, and the sequencer
// that derives the per-step scale factors. Depends on bsn_pkg and bsn_div.
module bsn_setup #(
  parameter int unsigned MAX_DIM = bsn_pkg::MAX_DIM_DEF,
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1),
  localparam int unsigned DIV_W  = DIM_W + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsn_pkg::REG_W-1:0]      cfg_wdata_i,
  input  logic [DIM_W-1:0]               col_rem_i,
  input  logic [DIM_W-1:0]               row_rem_i,
  output logic [DIM_W-1:0]               sw_o,
  output logic [DIM_W-1:0]               sh_o,
  output logic [DIM_W-1:0]               tw_o,
  output logic [DIM_W-1:0]               th_o,
  output logic [DIV_W-1:0]               col_base_q_o,
  output logic [DIM_W-1:0]               col_base_r_o,
  output logic [DIV_W-1:0]               col_fix_q_o,
  output logic [DIM_W-1:0]               col_fix_r_o,
  output logic [DIV_W-1:0]               row_base_q_o,
  output logic [DIM_W-1:0]               row_base_r_o,
  output logic [DIV_W-1:0]               row_fix_q_o,
  output logic [DIM_W-1:0]               row_fix_r_o,
  output bsn_pkg::seq_status_t           status_o
);

  import bsn_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD     = 6'b000001,
    S_COL_BASE = 6'b000010,
    S_COL_FIX  = 6'b000100,
    S_ROW_BASE = 6'b001000,
    S_ROW_FIX  = 6'b010000,
    S_IDLE     = 6'b100000
  } seq_state_e;

  logic [REG_W-1:0] src_w_q, src_w_d, src_h_q, src_h_d;
  logic [REG_W-1:0] tile_w_q, tile_w_d, tile_h_q, tile_h_d;
  logic [DIM_W-1:0] sw_q, sh_q, tw_q, th_q;
  seq_state_e       state_q, state_d;
  logic             start_q, start_d;
  logic             fix_load;
  logic [DIV_W-1:0] dividend;
  logic [DIM_W-1:0] divisor;
  logic             div_done;
  logic             div_fin;
  logic [DIV_W-1:0] div_quo;
  logic [DIM_W-1:0] div_rem;
  logic [DIV_W-1:0] col_bq_q, col_fq_q, row_bq_q, row_fq_q;
  logic [DIM_W-1:0] col_br_q, col_fr_q, row_br_q, row_fr_q;

  // Source dimension: zero reads as one, large values saturate.
  function automatic logic [DIM_W-1:0] src_dim(logic [REG_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    if (t == 32'd0) begin
      t = 32'd1;
    end else if (t > MAX_DIM) begin
      t = 32'(MAX_DIM);
    end
    return t[DIM_W-1:0];
  endfunction

  // Tile dimension: saturated, kept even and no larger than the source.
  function automatic logic [DIM_W-1:0] tile_dim(logic [REG_W-1:0] v, logic [DIM_W-1:0] src);
    logic [31:0] t;
    t = 32'(v);
    if (t > MAX_DIM) begin
      t = 32'(MAX_DIM);
    end
    t[0] = 1'b0;
    if (t > 32'(src)) begin
      t = 32'(src);
    end
    t[0] = 1'b0;
    return t[DIM_W-1:0];
  endfunction

  // Register write decode.
  always_comb begin
    src_w_d  = src_w_q;
    src_h_d  = src_h_q;
    tile_w_d = tile_w_q;
    tile_h_d = tile_h_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_WIDTH:   src_w_d  = cfg_wdata_i;
        CFG_SRC_HEIGHT:  src_h_d  = cfg_wdata_i;
        CFG_TILE_WIDTH:  tile_w_d = cfg_wdata_i;
        CFG_TILE_HEIGHT: tile_h_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= SRC_WIDTH_RST;
      src_h_q  <= SRC_HEIGHT_RST;
      tile_w_q <= TILE_WIDTH_RST;
      tile_h_q <= TILE_HEIGHT_RST;
    end else begin
      src_w_q  <= src_w_d;
      src_h_q  <= src_h_d;
      tile_w_q <= tile_w_d;
      tile_h_q <= tile_h_d;
    end
  end

  // Effective sizes, settled during the load state of the sequencer.
  always_ff @(posedge clk_i) begin
    sw_q <= src_dim(src_w_q);
    sh_q <= src_dim(src_h_q);
    tw_q <= tile_dim(tile_w_q, src_dim(src_w_q));
    th_q <= tile_dim(tile_h_q, src_dim(src_h_q));
  end

  // A done pulse that meets a fresh start belongs to an abandoned division.
  assign div_fin = div_done && !start_q;

  // Sequencer: base quotient and remainder of size over tile size, then the
  // correction for the first step from the remainder left in the counters.
  always_comb begin
    state_d  = state_q;
    start_d  = 1'b0;
    fix_load = 1'b0;
    if (cfg_we_i) begin
      state_d = S_LOAD;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          state_d = S_COL_BASE;
          start_d = 1'b1;
        end
        S_COL_BASE: begin
          if (div_fin) begin
            state_d = S_COL_FIX;
            start_d = 1'b1;
          end
        end
        S_COL_FIX: begin
          if (div_fin) begin
            state_d = S_ROW_BASE;
            start_d = 1'b1;
          end
        end
        S_ROW_BASE: begin
          if (div_fin) begin
            state_d = S_ROW_FIX;
            start_d = 1'b1;
          end
        end
        S_ROW_FIX: begin
          if (div_fin) begin
            state_d  = S_IDLE;
            fix_load = 1'b1;
          end
        end
        S_IDLE: ;
        default: state_d = S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
    end
  end

  // Divider operand selection.
  always_comb begin
    case (state_q)
      S_COL_FIX: begin
        dividend = DIV_W'(col_rem_i) + DIV_W'(col_br_q);
        divisor  = tw_q;
      end
      S_ROW_BASE: begin
        dividend = DIV_W'(sh_q);
        divisor  = th_q;
      end
      S_ROW_FIX: begin
        dividend = DIV_W'(row_rem_i) + DIV_W'(row_br_q);
        divisor  = th_q;
      end
      default: begin
        dividend = DIV_W'(sw_q);
        divisor  = tw_q;
      end
    endcase
  end

  bsn_div #(
    .DEND_W(DIV_W),
    .DSOR_W(DIM_W)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (start_q),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  // Capture each division result as it completes.
  always_ff @(posedge clk_i) begin
    if (div_fin && state_q == S_COL_BASE) begin
      col_bq_q <= div_quo;
      col_br_q <= div_rem;
    end
    if (div_fin && state_q == S_COL_FIX) begin
      col_fq_q <= div_quo;
      col_fr_q <= div_rem;
    end
    if (div_fin && state_q == S_ROW_BASE) begin
      row_bq_q <= div_quo;
      row_br_q <= div_rem;
    end
    if (div_fin && state_q == S_ROW_FIX) begin
      row_fq_q <= div_quo;
      row_fr_q <= div_rem;
    end
  end

  assign sw_o         = sw_q;
  assign sh_o         = sh_q;
  assign tw_o         = tw_q;
  assign th_o         = th_q;
  assign col_base_q_o = col_bq_q;
  assign col_base_r_o = col_br_q;
  assign col_fix_q_o  = col_fq_q;
  assign col_fix_r_o  = col_fr_q;
  assign row_base_q_o = row_bq_q;
  assign row_base_r_o = row_br_q;
  assign row_fix_q_o  = row_fq_q;
  assign row_fix_r_o  = row_fr_q;

  assign status_o.busy     = state_q != S_IDLE;
  assign status_o.fix_load = fix_load;

endmodule

/* rtl/core/bsn_csc.sv */
// BT.601 full-range color conversion of one pixel, rounded and clamped.
// Depends on bsn_pkg for coefficients and the clamp helper.
module bsn_csc (
  input  logic [bsn_pkg::PIX_W-1:0] red_i,
  input  logic [bsn_pkg::PIX_W-1:0] green_i,
  input  logic [bsn_pkg::PIX_W-1:0] blue_i,
  output logic [bsn_pkg::PIX_W-1:0] luma_o,
  output logic [bsn_pkg::PIX_W-1:0] cb_o,
  output logic [bsn_pkg::PIX_W-1:0] cr_o
);

  import bsn_pkg::*;

  logic signed [ACC_W-1:0] rs, gs, bs;
  logic signed [ACC_W-1:0] y_acc, cb_acc, cr_acc;

  assign rs = signed'(ACC_W'(red_i));
  assign gs = signed'(ACC_W'(green_i));
  assign bs = signed'(ACC_W'(blue_i));

  // Weighted sums with the offset and rounding half folded in.
  assign y_acc  = Y_R * rs + Y_G * gs + Y_B * bs + ROUND_HALF;
  assign cb_acc = CHROMA_OFS - CB_R * rs - CB_G * gs + CB_B * bs;
  assign cr_acc = CHROMA_OFS + CR_R * rs - CR_G * gs - CR_B * bs;

  assign luma_o = clamp8(y_acc);
  assign cb_o   = clamp8(cb_acc);
  assign cr_o   = clamp8(cr_acc);

endmodule

/* rtl/core/bsn_core.sv */
// Pixel datapath: input register, position tracking, sampling decision and
// result register. Depends on bsn_pkg and bsn_csc.
module bsn_core #(
  parameter int unsigned MAX_DIM = bsn_pkg::MAX_DIM_DEF,
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1),
  localparam int unsigned DIV_W  = DIM_W + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [DIM_W-1:0]          sw_i,
  input  logic [DIM_W-1:0]          sh_i,
  input  logic [DIM_W-1:0]          tw_i,
  input  logic [DIM_W-1:0]          th_i,
  input  logic [DIV_W-1:0]          col_base_q_i,
  input  logic [DIM_W-1:0]          col_base_r_i,
  input  logic [DIV_W-1:0]          col_fix_q_i,
  input  logic [DIM_W-1:0]          col_fix_r_i,
  input  logic [DIV_W-1:0]          row_base_q_i,
  input  logic [DIM_W-1:0]          row_base_r_i,
  input  logic [DIV_W-1:0]          row_fix_q_i,
  input  logic [DIM_W-1:0]          row_fix_r_i,
  input  bsn_pkg::seq_status_t      status_i,
  output logic [DIM_W-1:0]          col_rem_o,
  output logic [DIM_W-1:0]          row_rem_o,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bsn_pkg::PIX_W-1:0] blue_i,
  input  logic [bsn_pkg::PIX_W-1:0] green_i,
  input  logic [bsn_pkg::PIX_W-1:0] red_i,
  input  logic                      frame_start_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bsn_pkg::PIX_W-1:0] luma_o,
  output logic [bsn_pkg::PIX_W-1:0] chroma_blue_o,
  output logic [bsn_pkg::PIX_W-1:0] chroma_red_o,
  output logic                      chroma_valid_o,
  output logic [bsn_pkg::POS_W-1:0] tile_col_o,
  output logic [bsn_pkg::POS_W-1:0] tile_row_o,
  output logic                      tile_last_o
);

  import bsn_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned DW1   = DIM_W + 1;
  localparam int unsigned QW    = DIV_W + 1;

  // Input register.
  logic             in_vld_q, in_vld_d;
  logic [PIX_W-1:0] blue_q, green_q, red_q;
  logic             fs_q;
  logic             adv, in_take, proc;

  // Position state.
  logic [CNT_W-1:0] scc_q, scc_d, src_q, src_d, tcc_q, tcc_d, trc_q, trc_d;
  logic [POS_W-1:0] nsc_q, nsc_d, nsr_q, nsr_d;
  logic [DIM_W-1:0] crem_q, crem_d, rrem_q, rrem_d;
  logic             cfix_q, cfix_d, rfix_q, rfix_d;

  // State as seen after an optional frame start.
  logic [CNT_W-1:0] scc_c, src_c, tcc_c, trc_c;
  logic [POS_W-1:0] nsc_c, nsr_c;
  logic [DIM_W-1:0] crem_c, rrem_c;
  logic             cfix_c, rfix_c;

  logic             row_hit, col_hit, chroma_hit, last_hit;
  logic [DW1-1:0]   scc_p1, src_p1, tcc_p1, trc_p1;
  logic             tcc_more, trc_more;
  logic [DIV_W-1:0] col_t, row_t;
  logic             col_ge, row_ge;
  logic [QW-1:0]    col_qsum, row_qsum;
  logic [DIM_W-1:0] col_rn, row_rn;
  logic [POS_W-1:0] nsc_adv, nsr_adv;

  logic [PIX_W-1:0] y_pix, cb_pix, cr_pix;

  // Result register.
  logic             out_vld_q, out_vld_d;
  logic [PIX_W-1:0] luma_q, cb_q, cr_q;
  logic             cv_q, last_q;
  logic [POS_W-1:0] tcol_q, trow_q;

  // Handshake: the input register moves on whenever the result register can.
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = status_i.busy || (in_vld_q && !adv);
  assign in_take    = in_valid_i && !in_stall_o;
  assign proc       = in_vld_q && adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      blue_q  <= blue_i;
      green_q <= green_i;
      red_q   <= red_i;
      fs_q    <= frame_start_i;
    end
  end

  // A frame start clears every counter before the pixel is looked at.
  assign scc_c  = fs_q ? '0 : scc_q;
  assign src_c  = fs_q ? '0 : src_q;
  assign tcc_c  = fs_q ? '0 : tcc_q;
  assign trc_c  = fs_q ? '0 : trc_q;
  assign nsc_c  = fs_q ? '0 : nsc_q;
  assign nsr_c  = fs_q ? '0 : nsr_q;
  assign crem_c = fs_q ? '0 : crem_q;
  assign rrem_c = fs_q ? '0 : rrem_q;
  assign cfix_c = fs_q ? 1'b0 : cfix_q;
  assign rfix_c = fs_q ? 1'b0 : rfix_q;

  // Sampling decision for this pixel.
  assign row_hit = (th_i != '0) && (32'(trc_c) < 32'(th_i)) && (32'(src_c) == 32'(nsr_c));
  assign col_hit = row_hit && (tw_i != '0) && (32'(tcc_c) < 32'(tw_i)) &&
                   (32'(scc_c) == 32'(nsc_c));
  assign chroma_hit = !tcc_c[0] && !trc_c[0];

  assign scc_p1   = DW1'(scc_c) + DW1'(1);
  assign src_p1   = DW1'(src_c) + DW1'(1);
  assign tcc_p1   = DW1'(tcc_c) + DW1'(1);
  assign trc_p1   = DW1'(trc_c) + DW1'(1);
  assign tcc_more = tcc_p1 < DW1'(tw_i);
  assign trc_more = trc_p1 < DW1'(th_i);
  assign last_hit = (tcc_p1 == DW1'(tw_i)) && (trc_p1 == DW1'(th_i));

  // Next sampled column: base step plus one when the remainder wraps. The
  // first step after a size change uses the correction from the sequencer.
  assign col_t    = DIV_W'(crem_c) + DIV_W'(col_base_r_i);
  assign col_ge   = col_t >= DIV_W'(tw_i);
  assign col_qsum = QW'(col_base_q_i) + (cfix_c ? QW'(col_fix_q_i) : QW'(col_ge));
  assign col_rn   = cfix_c ? col_fix_r_i :
                    (col_ge ? DIM_W'(col_t - DIV_W'(tw_i)) : DIM_W'(col_t));
  assign nsc_adv  = POS_W'(32'(nsc_c) + 32'(col_qsum));

  // Same for the next sampled row.
  assign row_t    = DIV_W'(rrem_c) + DIV_W'(row_base_r_i);
  assign row_ge   = row_t >= DIV_W'(th_i);
  assign row_qsum = QW'(row_base_q_i) + (rfix_c ? QW'(row_fix_q_i) : QW'(row_ge));
  assign row_rn   = rfix_c ? row_fix_r_i :
                    (row_ge ? DIM_W'(row_t - DIV_W'(th_i)) : DIM_W'(row_t));
  assign nsr_adv  = POS_W'(32'(nsr_c) + 32'(row_qsum));

  // Counter update for one processed pixel.
  always_comb begin
    scc_d  = scc_q;
    src_d  = src_q;
    tcc_d  = tcc_q;
    trc_d  = trc_q;
    nsc_d  = nsc_q;
    nsr_d  = nsr_q;
    crem_d = crem_q;
    rrem_d = rrem_q;
    cfix_d = cfix_q;
    rfix_d = rfix_q;
    if (proc) begin
      scc_d  = scc_c;
      src_d  = src_c;
      tcc_d  = tcc_c;
      trc_d  = trc_c;
      nsc_d  = nsc_c;
      nsr_d  = nsr_c;
      crem_d = crem_c;
      rrem_d = rrem_c;
      cfix_d = cfix_c;
      rfix_d = rfix_c;
      // Advance along the tile row after a sample; wrap after the last one.
      if (col_hit) begin
        if (tcc_more) begin
          tcc_d  = CNT_W'(tcc_p1);
          nsc_d  = nsc_adv;
          crem_d = col_rn;
          cfix_d = 1'b0;
        end else begin
          tcc_d = '0;
        end
      end
      // End of a source row clears the column tracking.
      if (scc_p1 >= DW1'(sw_i)) begin
        scc_d  = '0;
        tcc_d  = '0;
        nsc_d  = '0;
        crem_d = '0;
        cfix_d = 1'b0;
        if (row_hit) begin
          if (trc_more) begin
            trc_d  = CNT_W'(trc_p1);
            nsr_d  = nsr_adv;
            rrem_d = row_rn;
            rfix_d = 1'b0;
          end else begin
            trc_d = '0;
          end
        end
        // End of the frame clears the row tracking.
        if (src_p1 >= DW1'(sh_i)) begin
          src_d  = '0;
          trc_d  = '0;
          nsr_d  = '0;
          rrem_d = '0;
          rfix_d = 1'b0;
        end else begin
          src_d = CNT_W'(src_p1);
        end
      end else begin
        scc_d = CNT_W'(scc_p1);
      end
    end
    if (status_i.fix_load) begin
      cfix_d = 1'b1;
      rfix_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      scc_q     <= '0;
      src_q     <= '0;
      tcc_q     <= '0;
      trc_q     <= '0;
      nsc_q     <= '0;
      nsr_q     <= '0;
      crem_q    <= '0;
      rrem_q    <= '0;
      cfix_q    <= 1'b0;
      rfix_q    <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      scc_q     <= scc_d;
      src_q     <= src_d;
      tcc_q     <= tcc_d;
      trc_q     <= trc_d;
      nsc_q     <= nsc_d;
      nsr_q     <= nsr_d;
      crem_q    <= crem_d;
      rrem_q    <= rrem_d;
      cfix_q    <= cfix_d;
      rfix_q    <= rfix_d;
    end
  end

  bsn_csc u_csc (
    .red_i  (red_q),
    .green_i(green_q),
    .blue_i (blue_q),
    .luma_o (y_pix),
    .cb_o   (cb_pix),
    .cr_o   (cr_pix)
  );

  // Result register: loaded when a sampled pixel is processed.
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = proc && col_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && col_hit) begin
      luma_q <= y_pix;
      cb_q   <= chroma_hit ? cb_pix : CHROMA_MID;
      cr_q   <= chroma_hit ? cr_pix : CHROMA_MID;
      cv_q   <= chroma_hit;
      tcol_q <= POS_W'(tcc_c);
      trow_q <= POS_W'(trc_c);
      last_q <= last_hit;
    end
  end

  assign col_rem_o      = crem_q;
  assign row_rem_o      = rrem_q;
  assign out_valid_o    = out_vld_q;
  assign luma_o         = luma_q;
  assign chroma_blue_o  = cb_q;
  assign chroma_red_o   = cr_q;
  assign chroma_valid_o = cv_q;
  assign tile_col_o     = tcol_q;
  assign tile_row_o     = trow_q;
  assign tile_last_o    = last_q;

endmodule

/* rtl/core/bsn_checker.sv */
// Port-level checks for the BGR scaler to NV12 unit, bound to the top level.
// Depends on bsn_pkg for the port widths and the neutral chroma value.
module bsn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bsn_pkg::PIX_W-1:0]     luma_o,
  input logic [bsn_pkg::PIX_W-1:0]     chroma_blue_o,
  input logic [bsn_pkg::PIX_W-1:0]     chroma_red_o,
  input logic                          chroma_valid_o,
  input logic [bsn_pkg::POS_W-1:0]     tile_col_o,
  input logic [bsn_pkg::POS_W-1:0]     tile_row_o,
  input logic                          tile_last_o
);

  import bsn_pkg::*;

  // A stalled item stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(luma_o) &&
      $stable(chroma_blue_o) && $stable(chroma_red_o) && $stable(chroma_valid_o) &&
      $stable(tile_col_o) && $stable(tile_row_o) && $stable(tile_last_o))
    else $error("output item changed while stalled");

  // New sizes need new step factors before any pixel is taken.
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input taken while step factors are recomputed");

  // Samples without chroma carry the neutral value.
  a_chroma_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_valid_o |-> chroma_blue_o == CHROMA_MID &&
      chroma_red_o == CHROMA_MID)
    else $error("chroma not neutral on a luma-only sample");

  // Chroma is only carried at even tile row and column.
  a_chroma_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chroma_valid_o |-> !tile_col_o[0] && !tile_row_o[0])
    else $error("chroma sample at an odd tile position");

endmodule

bind bgr_scale_to_nv12_unit bsn_checker u_bsn_checker (.*);
